[rtl/lphm_pkg.sv]
// Package for the linear probe hash map unit: item and configuration types,
// status and action codes, slot state codes and the three-part home hash.
// Depends on nothing; every other file in rtl uses it.
package lphm_pkg;

    localparam int SLOT_BITS = 10;
    localparam int DEPTH     = 1 << SLOT_BITS;

    // Action codes carried in s_tuser.
    localparam logic [1:0] ACT_PUT      = 2'd0;
    localparam logic [1:0] ACT_FIND     = 2'd1;
    localparam logic [1:0] ACT_DEL_KEY  = 2'd2;
    localparam logic [1:0] ACT_DEL_SLOT = 2'd3;

    // Slot state codes held in the status store.
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_DEAD  = 2'd1;
    localparam logic [1:0] ST_USED  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIZE_LOG2   = 2'd0;
    localparam logic [1:0] CFG_LOAD_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_HASH_SELECT = 2'd2;

    // Result status codes carried in m_tuser.
    typedef enum logic [2:0] {
        RES_INSERTED    = 3'd0,
        RES_OVERWRITTEN = 3'd1,
        RES_FOUND       = 3'd2,
        RES_ABSENT      = 3'd3,
        RES_DELETED     = 3'd4,
        RES_FULL        = 3'd5,
        RES_NOT_USED    = 3'd6
    } status_t;

    typedef struct packed {
        logic [3:0]  size_log2;
        logic [9:0]  load_limit;
        logic [1:0]  hash_select;
        logic        clear_req;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           action;
        logic signed [31:0]   key;
        logic signed [31:0]   value;
        logic [9:0]           slot;
        logic [SLOT_BITS-1:0] home;
    } item_t;

    // Hash constants.
    localparam logic [31:0] H0_C0 = 32'h7ed55d16;
    localparam logic [31:0] H0_C1 = 32'hc761c23c;
    localparam logic [31:0] H0_C2 = 32'h165667b1;
    localparam logic [31:0] H0_C3 = 32'hd3a2646c;
    localparam logic [31:0] H0_C4 = 32'hfd7046c5;
    localparam logic [31:0] H0_C5 = 32'hb55a4f09;
    localparam logic [31:0] H1_MUL = 32'h27d4eb2d;
    localparam logic [31:0] H1_XOR = 32'd61;
    localparam logic [31:0] H2_C0 = 32'h479ab41d;
    localparam logic [31:0] H2_C1 = 32'he4aa10ce;
    localparam logic [31:0] H2_C2 = 32'h9942f0a6;
    localparam logic [31:0] H2_C3 = 32'h5aedd67d;
    localparam logic [31:0] H2_C4 = 32'h17bea992;

    // First third of the selected hash.
    function automatic logic [31:0] hash_part1(input logic [31:0] a, input logic [1:0] sel);
        logic [31:0] x;
        x = a;
        case (sel)
            2'd0: begin
                x = (x + H0_C0) + (x << 12);
                x = (x ^ H0_C1) ^ (x >> 19);
            end
            2'd1: begin
                x = (x ^ H1_XOR) ^ (x >> 16);
                x = x + (x << 3);
                x = x ^ (x >> 4);
            end
            2'd2: begin
                x = (x + H2_C0) + (x << 8);
                x = (x ^ H2_C1) ^ (x >> 5);
            end
            default: begin
                x = x - (x << 6);
                x = x ^ (x >> 17);
                x = x - (x << 9);
            end
        endcase
        return x;
    endfunction

    // Middle third; holds the multiplier of the multiply hash.
    function automatic logic [31:0] hash_part2(input logic [31:0] a, input logic [1:0] sel);
        logic [31:0] x;
        x = a;
        case (sel)
            2'd0: begin
                x = (x + H0_C2) + (x << 5);
                x = (x + H0_C3) ^ (x << 9);
            end
            2'd1: begin
                x = x * H1_MUL;
            end
            2'd2: begin
                x = (x + H2_C2) - (x << 14);
                x = (x ^ H2_C3) ^ (x >> 3);
            end
            default: begin
                x = x ^ (x << 4);
                x = x - (x << 3);
            end
        endcase
        return x;
    endfunction

    // Last third.
    function automatic logic [31:0] hash_part3(input logic [31:0] a, input logic [1:0] sel);
        logic [31:0] x;
        x = a;
        case (sel)
            2'd0: begin
                x = (x + H0_C4) + (x << 3);
                x = (x ^ H0_C5) ^ (x >> 16);
            end
            2'd1: begin
                x = x ^ (x >> 15);
            end
            2'd2: begin
                x = (x + H2_C4) + (x << 7);
            end
            default: begin
                x = x ^ (x << 10);
                x = x ^ (x >> 15);
            end
        endcase
        return x;
    endfunction

endpackage

[rtl/linear_probe_hash_map_unit.sv]
// Top level of the linear probe hash map unit: configuration registers and
// the front end, queue and back end. Depends on lphm_pkg, lphm_front,
// lphm_fifo and lphm_back.

// The unit maps 32-bit keys to 32-bit values in a store of up to 1024 slots,
// with linear probing and tombstones. After reset, and again after every
// write of size_log2, a clearing pass over all 1024 slots empties the slot
// status store; requests are queued but not carried out until it ends, while
// configuration writes are taken at all times. The front end holds one
// request through acceptance, three hash steps and the hand-over to a
// two-entry queue, and takes no new request before that hand-over, which waits
// while the queue is full. The back end takes a request, probes a run of
// slots through the registered read port of the slot stores, and then loads
// the result register. A delete then reads the neighbours of the freed slot
// and, if one is empty, walks away from it clearing tombstones. Put on a full
// table and delete by slot out of range skip the probe.
module linear_probe_hash_map_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key [31:0], value [63:32], slot [73:64], zero pad
    input  logic [1:0]  s_tuser,   // action [1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // slot_index [9:0], entry_key [41:10],
                                   // entry_value [73:42], loaded_cells [84:74], zero pad
    output logic [2:0]  m_tuser,   // status [2:0]
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    logic [3:0]      size_log2_reg;
    logic [9:0]      load_limit_reg;
    logic [1:0]      hash_select_reg;
    logic            clear_req_reg;
    lphm_pkg::cfg_t  cfg;

    logic            q_wr, q_full, q_rd, q_empty;
    lphm_pkg::item_t q_wr_data, q_rd_data;

    // Configuration writes are always taken; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg   <= 4'd8;
            load_limit_reg  <= 10'd192;
            hash_select_reg <= 2'd0;
            clear_req_reg   <= 1'b0;
        end else begin
            clear_req_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    lphm_pkg::CFG_SIZE_LOG2: begin
                        size_log2_reg <= cfg_data[3:0];
                        clear_req_reg <= 1'b1;
                    end
                    lphm_pkg::CFG_LOAD_LIMIT:  load_limit_reg  <= cfg_data;
                    lphm_pkg::CFG_HASH_SELECT: hash_select_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        cfg.size_log2   = size_log2_reg;
        cfg.load_limit  = load_limit_reg;
        cfg.hash_select = hash_select_reg;
        cfg.clear_req   = clear_req_reg;
    end

    lphm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data),
        .q_full    (q_full)
    );

    lphm_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    lphm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_rd_data (q_rd_data),
        .q_rd      (q_rd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/lphm_front.sv]
// Front end of the hash map unit: accepts an item and works out its home slot
// in three registered hash steps, then hands it to the queue.
// Depends on lphm_pkg.
module lphm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  lphm_pkg::cfg_t      cfg,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [79:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    output logic                q_wr,
    output lphm_pkg::item_t     q_wr_data,
    input  logic                q_full
);

    logic            busy_reg;
    logic [1:0]      phase_reg;
    logic [31:0]     hash_reg;
    lphm_pkg::item_t item_reg;

    assign s_tready = !busy_reg;
    assign q_wr     = busy_reg && (phase_reg == 2'd3) && !q_full;

    always_comb begin
        q_wr_data      = item_reg;
        q_wr_data.home = hash_reg[lphm_pkg::SLOT_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
        end else if (!busy_reg) begin
            if (s_tvalid) begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
        end else if (phase_reg != 2'd3) begin
            phase_reg <= phase_reg + 2'd1;
        end else if (!q_full) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && s_tvalid) begin
            item_reg.action <= s_tuser;
            item_reg.key    <= s_tdata[31:0];
            item_reg.value  <= s_tdata[63:32];
            item_reg.slot   <= s_tdata[73:64];
            item_reg.home   <= '0;
            hash_reg        <= s_tdata[31:0];
        end else if (busy_reg) begin
            case (phase_reg)
                2'd0:    hash_reg <= lphm_pkg::hash_part1(hash_reg, cfg.hash_select);
                2'd1:    hash_reg <= lphm_pkg::hash_part2(hash_reg, cfg.hash_select);
                2'd2:    hash_reg <= lphm_pkg::hash_part3(hash_reg, cfg.hash_select);
                default: hash_reg <= hash_reg;
            endcase
        end
    end

endmodule

[rtl/lphm_fifo.sv]
// Two-entry queue between the front and back ends of the hash map unit.
// Depends on lphm_pkg for the item type.
module lphm_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  lphm_pkg::item_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output lphm_pkg::item_t rd_data,
    output logic            empty
);

    lphm_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en) rd_ptr_reg <= !rd_ptr_reg;
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[rtl/lphm_back.sv]
// Back end of the hash map unit: the slot stores, the probe and tombstone
// walk sequencer, the load counters and the result register.
// Depends on lphm_pkg.
module lphm_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  lphm_pkg::cfg_t  cfg,
    input  logic            q_empty,
    input  lphm_pkg::item_t q_rd_data,
    output logic            q_rd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [87:0]     m_tdata,
    output logic [2:0]      m_tuser
);

    localparam int SB = lphm_pkg::SLOT_BITS;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_PROBE  = 9'b000000100,
        S_NB1    = 9'b000001000,
        S_NB2    = 9'b000010000,
        S_NB3    = 9'b000100000,
        S_WSTART = 9'b001000000,
        S_WALK   = 9'b010000000,
        S_FIN    = 9'b100000000
    } state_t;

    logic [1:0]  status_mem [lphm_pkg::DEPTH];
    logic [31:0] key_mem    [lphm_pkg::DEPTH];
    logic [31:0] value_mem  [lphm_pkg::DEPTH];

    state_t              state_reg, state_next;
    lphm_pkg::item_t     cur_reg, cur_next;
    logic [SB-1:0]       eval_reg, eval_next;
    logic [SB-1:0]       ptr_reg, ptr_next;
    logic [SB-1:0]       del_reg, del_next;
    logic [SB-1:0]       clr_reg, clr_next;
    logic [SB:0]         steps_reg, steps_next;
    logic                down_reg, down_next;
    logic [SB:0]         occ_reg, occ_next;
    logic [SB:0]         tomb_reg, tomb_next;
    lphm_pkg::status_t   res_status_reg, res_status_next;
    logic [9:0]          res_idx_reg, res_idx_next;
    logic [31:0]         res_key_reg, res_key_next;
    logic [31:0]         res_val_reg, res_val_next;
    logic                m_valid_reg;
    logic [87:0]         m_data_reg;
    logic [2:0]          m_user_reg;

    logic [1:0]          rd_status_reg;
    logic [31:0]         rd_key_reg;
    logic [31:0]         rd_val_reg;

    logic [SB-1:0]       rd_addr;
    logic [SB-1:0]       wr_addr;
    logic                st_we, key_we, val_we;
    logic [1:0]          st_wd;
    logic [31:0]         key_wd, val_wd;

    logic [3:0]          sz_eff;
    logic [SB:0]         n_full;
    logic [SB-1:0]       mask;
    logic [SB:0]         lim;
    logic [SB-1:0]       start_addr;
    logic                key_hit;
    logic                pop;
    logic                fin;

    // Slot count in use and the put limit, from the clamped size.
    always_comb begin
        if (cfg.size_log2 < 4'd2) sz_eff = 4'd2;
        else if (cfg.size_log2 > 4'(SB)) sz_eff = 4'(SB);
        else sz_eff = cfg.size_log2;
        n_full = (SB+1)'(1) << sz_eff;
        mask   = SB'(n_full - (SB+1)'(1));
        if ((SB+1)'(cfg.load_limit) < (n_full - (SB+1)'(1))) lim = (SB+1)'(cfg.load_limit);
        else lim = n_full - (SB+1)'(1);
    end

    function automatic logic [SB-1:0] walk_step(input logic [SB-1:0] x, input logic down,
                                                input logic [SB-1:0] msk);
        logic [SB-1:0] y;
        y = down ? ((x + msk) & msk) : ((x + SB'(1)) & msk);
        return y;
    endfunction

    assign pop      = (state_reg == S_IDLE) && !q_empty && !m_valid_reg;
    assign q_rd     = pop;
    assign key_hit  = (rd_status_reg == lphm_pkg::ST_USED) && (rd_key_reg == cur_reg.key);
    assign fin      = (state_reg == S_FIN);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        if (q_rd_data.action == lphm_pkg::ACT_DEL_SLOT) start_addr = SB'(q_rd_data.slot);
        else start_addr = q_rd_data.home & mask;
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        eval_next       = eval_reg;
        ptr_next        = ptr_reg;
        del_next        = del_reg;
        clr_next        = clr_reg;
        steps_next      = steps_reg;
        down_next       = down_reg;
        occ_next        = occ_reg;
        tomb_next       = tomb_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;
        rd_addr         = ptr_reg;
        wr_addr         = eval_reg;
        st_we           = 1'b0;
        key_we          = 1'b0;
        val_we          = 1'b0;
        st_wd           = lphm_pkg::ST_EMPTY;
        key_wd          = cur_reg.key;
        val_wd          = cur_reg.value;

        case (state_reg)
            S_CLEAR: begin
                wr_addr  = clr_reg;
                st_we    = 1'b1;
                clr_next = clr_reg + SB'(1);
                if (clr_reg == '1) state_next = S_IDLE;
            end
            S_IDLE: begin
                rd_addr = start_addr;
                if (pop) begin
                    cur_next     = q_rd_data;
                    eval_next    = start_addr;
                    ptr_next     = (start_addr + SB'(1)) & mask;
                    steps_next   = '0;
                    res_idx_next = '0;
                    res_key_next = '0;
                    res_val_next = '0;
                    state_next   = S_PROBE;
                    if (q_rd_data.action == lphm_pkg::ACT_PUT && !(occ_reg < lim)) begin
                        res_status_next = lphm_pkg::RES_FULL;
                        state_next      = S_FIN;
                    end else if (q_rd_data.action == lphm_pkg::ACT_DEL_SLOT &&
                                 !((SB+1)'(q_rd_data.slot) < n_full)) begin
                        res_status_next = lphm_pkg::RES_NOT_USED;
                        res_idx_next    = q_rd_data.slot;
                        state_next      = S_FIN;
                    end
                end
            end
            S_PROBE: begin
                rd_addr = ptr_reg;
                if (cur_reg.action == lphm_pkg::ACT_DEL_SLOT) begin
                    // Delete by slot looks at the given slot alone.
                    res_idx_next = cur_reg.slot;
                    if (rd_status_reg == lphm_pkg::ST_USED) begin
                        res_status_next = lphm_pkg::RES_DELETED;
                        res_key_next    = rd_key_reg;
                        res_val_next    = rd_val_reg;
                        del_next        = eval_reg;
                        st_we           = 1'b1;
                        st_wd           = lphm_pkg::ST_DEAD;
                        tomb_next       = tomb_reg + (SB+1)'(1);
                        state_next      = S_NB1;
                    end else begin
                        res_status_next = lphm_pkg::RES_NOT_USED;
                        state_next      = S_FIN;
                    end
                end else if (key_hit) begin
                    res_idx_next = 10'(eval_reg);
                    res_key_next = rd_key_reg;
                    case (cur_reg.action)
                        lphm_pkg::ACT_PUT: begin
                            val_we          = 1'b1;
                            res_val_next    = cur_reg.value;
                            res_status_next = lphm_pkg::RES_OVERWRITTEN;
                            state_next      = S_FIN;
                        end
                        lphm_pkg::ACT_FIND: begin
                            res_val_next    = rd_val_reg;
                            res_status_next = lphm_pkg::RES_FOUND;
                            state_next      = S_FIN;
                        end
                        default: begin
                            res_val_next    = rd_val_reg;
                            res_status_next = lphm_pkg::RES_DELETED;
                            del_next        = eval_reg;
                            st_we           = 1'b1;
                            st_wd           = lphm_pkg::ST_DEAD;
                            tomb_next       = tomb_reg + (SB+1)'(1);
                            state_next      = S_NB1;
                        end
                    endcase
                end else if (rd_status_reg == lphm_pkg::ST_EMPTY) begin
                    if (cur_reg.action == lphm_pkg::ACT_PUT) begin
                        st_we           = 1'b1;
                        st_wd           = lphm_pkg::ST_USED;
                        key_we          = 1'b1;
                        val_we          = 1'b1;
                        occ_next        = occ_reg + (SB+1)'(1);
                        res_idx_next    = 10'(eval_reg);
                        res_key_next    = cur_reg.key;
                        res_val_next    = cur_reg.value;
                        res_status_next = lphm_pkg::RES_INSERTED;
                    end else begin
                        res_status_next = lphm_pkg::RES_ABSENT;
                    end
                    state_next = S_FIN;
                end else if (steps_reg == (n_full - (SB+1)'(1))) begin
                    // Every slot in use was probed without an empty one.
                    if (cur_reg.action == lphm_pkg::ACT_PUT) res_status_next = lphm_pkg::RES_FULL;
                    else res_status_next = lphm_pkg::RES_ABSENT;
                    state_next = S_FIN;
                end else begin
                    eval_next  = ptr_reg;
                    ptr_next   = (ptr_reg + SB'(1)) & mask;
                    steps_next = steps_reg + (SB+1)'(1);
                end
            end
            S_NB1: begin
                rd_addr    = (del_reg + SB'(1)) & mask;
                state_next = S_NB2;
            end
            S_NB2: begin
                rd_addr = (del_reg + mask) & mask;
                if (rd_status_reg == lphm_pkg::ST_EMPTY) begin
                    down_next  = 1'b1;
                    state_next = S_WSTART;
                end else begin
                    state_next = S_NB3;
                end
            end
            S_NB3: begin
                if (rd_status_reg == lphm_pkg::ST_EMPTY) begin
                    down_next  = 1'b0;
                    state_next = S_WSTART;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_WSTART: begin
                rd_addr    = del_reg;
                eval_next  = del_reg;
                ptr_next   = walk_step(del_reg, down_reg, mask);
                steps_next = '0;
                state_next = S_WALK;
            end
            S_WALK: begin
                rd_addr = ptr_reg;
                if (rd_status_reg == lphm_pkg::ST_DEAD && steps_reg != n_full) begin
                    st_we      = 1'b1;
                    st_wd      = lphm_pkg::ST_EMPTY;
                    if (tomb_reg != '0) tomb_next = tomb_reg - (SB+1)'(1);
                    if (occ_reg != '0) occ_next = occ_reg - (SB+1)'(1);
                    eval_next  = ptr_reg;
                    ptr_next   = walk_step(ptr_reg, down_reg, mask);
                    steps_next = steps_reg + (SB+1)'(1);
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.clear_req) begin
            state_next = S_CLEAR;
            clr_next   = '0;
            occ_next   = '0;
            tomb_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            occ_reg     <= '0;
            tomb_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            occ_reg   <= occ_next;
            tomb_reg  <= tomb_next;
            if (fin) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        eval_reg       <= eval_next;
        ptr_reg        <= ptr_next;
        del_reg        <= del_next;
        steps_reg      <= steps_next;
        down_reg       <= down_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_key_reg    <= res_key_next;
        res_val_reg    <= res_val_next;
        if (fin) begin
            m_data_reg <= {3'b000, occ_reg, res_val_reg, res_key_reg, res_idx_reg};
            m_user_reg <= res_status_reg;
        end
    end

    // Slot stores: one write and one shared read address, read data registered.
    always_ff @(posedge aclk) begin
        if (st_we)  status_mem[wr_addr] <= st_wd;
        if (key_we) key_mem[wr_addr]    <= key_wd;
        if (val_we) value_mem[wr_addr]  <= val_wd;
        rd_status_reg <= status_mem[rd_addr];
        rd_key_reg    <= key_mem[rd_addr];
        rd_val_reg    <= value_mem[rd_addr];
    end

endmodule

[tb/tb_linear_probe_hash_map_unit.sv]
// Self-checking testbench for linear_probe_hash_map_unit: a built-in model of
// the slot store predicts every result, and several table settings are run.
// Depends on lphm_pkg and the unit's RTL.
module tb_linear_probe_hash_map_unit;
    import lphm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Hash choices as written to the hash_select register.
    localparam logic [1:0] HASH_SIX_STEP = 2'd0;
    localparam logic [1:0] HASH_MULTIPLY = 2'd1;
    localparam logic [1:0] HASH_FIVE_SHIFT = 2'd2;
    localparam logic [1:0] HASH_SHIFT_ONLY = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]  action;
        logic [31:0] key;
        logic [31:0] value;
        logic [9:0]  slot;
    } map_request_t;

    typedef struct {
        status_t     status;
        logic [9:0]  slot_index;
        logic [31:0] entry_key;
        logic [31:0] entry_value;
        logic [10:0] loaded_cells;
    } map_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;

    // Requests waiting to be driven, and results the model has predicted.
    map_request_t request_queue[$];
    map_result_t  predicted_results[$];
    map_request_t driven_request;
    logic [31:0]  key_pool[$];

    // Model copy of the table and its settings.
    logic [1:0]  model_state [DEPTH];
    logic [31:0] model_key   [DEPTH];
    logic [31:0] model_value [DEPTH];
    int unsigned model_loaded;
    int unsigned model_dead;
    logic [3:0]  model_size_log2;
    logic [9:0]  model_load_limit;
    logic [1:0]  model_hash_select;

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_count = 0;
    int  quiet_cycles = 0;

    linear_probe_hash_map_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Number of slots in use, with size_log2 clamped to 2..SLOT_BITS.
    function automatic int unsigned table_slots();
        int unsigned s;
        s = model_size_log2;
        if (s < 2) s = 2;
        if (s > SLOT_BITS) s = SLOT_BITS;
        return 1 << s;
    endfunction

    function automatic logic [31:0] home_hash(input logic [31:0] a, input logic [1:0] sel);
        case (sel)
            HASH_SIX_STEP: begin
                a = (a + 32'h7ed55d16) + (a << 12);
                a = (a ^ 32'hc761c23c) ^ (a >> 19);
                a = (a + 32'h165667b1) + (a << 5);
                a = (a + 32'hd3a2646c) ^ (a << 9);
                a = (a + 32'hfd7046c5) + (a << 3);
                a = (a ^ 32'hb55a4f09) ^ (a >> 16);
            end
            HASH_MULTIPLY: begin
                a = (a ^ 32'd61) ^ (a >> 16);
                a = a + (a << 3);
                a = a ^ (a >> 4);
                a = a * 32'h27d4eb2d;
                a = a ^ (a >> 15);
            end
            HASH_FIVE_SHIFT: begin
                a = (a + 32'h479ab41d) + (a << 8);
                a = (a ^ 32'he4aa10ce) ^ (a >> 5);
                a = (a + 32'h9942f0a6) - (a << 14);
                a = (a ^ 32'h5aedd67d) ^ (a >> 3);
                a = (a + 32'h17bea992) + (a << 7);
            end
            default: begin
                a = a - (a << 6);
                a = a ^ (a >> 17);
                a = a - (a << 9);
                a = a ^ (a << 4);
                a = a - (a << 3);
                a = a ^ (a << 10);
                a = a ^ (a >> 15);
            end
        endcase
        return a;
    endfunction

    // Walks from the home slot; returns 1 on a key match. Otherwise 'at' is
    // the first empty slot, and reached_empty is 0 if the walk ran out.
    function automatic bit locate_key(input logic [31:0] key, output int unsigned at,
                                      output bit reached_empty);
        int unsigned n, i;
        n = table_slots();
        i = home_hash(key, model_hash_select) & (n - 1);
        reached_empty = 1'b0;
        at = 0;
        for (int unsigned step = 0; step < n; step++) begin
            if (model_state[i] == ST_USED && model_key[i] == key) begin
                at = i;
                return 1'b1;
            end
            if (model_state[i] == ST_EMPTY) begin
                at = i;
                reached_empty = 1'b1;
                return 1'b0;
            end
            i = (i + 1) & (n - 1);
        end
        return 1'b0;
    endfunction

    // Leaves a tombstone, then empties the run of tombstones that starts at
    // it, walking away from whichever neighbour is already empty.
    function automatic void retire_slot(input int unsigned s);
        int unsigned n, m, dir, i;
        n = table_slots();
        m = n - 1;
        model_state[s] = ST_DEAD;
        model_dead++;
        if (model_state[(s + 1) & m] == ST_EMPTY) dir = m;
        else if (model_state[(s + m) & m] == ST_EMPTY) dir = 1;
        else return;
        i = s;
        for (int unsigned step = 0; step < n && model_state[i] == ST_DEAD; step++) begin
            model_state[i] = ST_EMPTY;
            if (model_dead != 0) model_dead--;
            if (model_loaded != 0) model_loaded--;
            i = (i + dir) & m;
        end
    endfunction

    function automatic map_result_t apply_request(input map_request_t rq);
        map_result_t r;
        int unsigned n, lim, at;
        bit reached_empty;
        n = table_slots();
        r.status = RES_ABSENT;
        r.slot_index = '0;
        r.entry_key = '0;
        r.entry_value = '0;
        case (rq.action)
            ACT_PUT: begin
                lim = (model_load_limit < n - 1) ? model_load_limit : n - 1;
                r.status = RES_FULL;
                if (model_loaded < lim) begin
                    if (locate_key(rq.key, at, reached_empty)) begin
                        model_value[at] = rq.value;
                        r.status = RES_OVERWRITTEN;
                    end else if (reached_empty) begin
                        model_state[at] = ST_USED;
                        model_key[at] = rq.key;
                        model_value[at] = rq.value;
                        model_loaded++;
                        r.status = RES_INSERTED;
                    end
                    if (r.status != RES_FULL) begin
                        r.slot_index = 10'(at);
                        r.entry_key = model_key[at];
                        r.entry_value = model_value[at];
                    end
                end
            end
            ACT_FIND, ACT_DEL_KEY: begin
                if (locate_key(rq.key, at, reached_empty)) begin
                    r.slot_index = 10'(at);
                    r.entry_key = model_key[at];
                    r.entry_value = model_value[at];
                    r.status = RES_FOUND;
                    if (rq.action == ACT_DEL_KEY) begin
                        retire_slot(at);
                        r.status = RES_DELETED;
                    end
                end
            end
            default: begin
                r.slot_index = rq.slot;
                r.status = RES_NOT_USED;
                if (rq.slot < n && model_state[rq.slot] == ST_USED) begin
                    r.entry_key = model_key[rq.slot];
                    r.entry_value = model_value[rq.slot];
                    retire_slot(rq.slot);
                    r.status = RES_DELETED;
                end
            end
        endcase
        r.loaded_cells = model_loaded[10:0];
        return r;
    endfunction

    // Sender: presents the next queued request and holds it until taken.
    // The model is stepped on every accepted request, in acceptance order.
    always @(posedge aclk) begin
        bit offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_results.push_back(apply_request(driven_request));
            if (!(s_tvalid && !s_tready)) begin
                offer = request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct;
                if (offer) begin
                    driven_request = request_queue.pop_front();
                    s_tdata <= {6'b0, driven_request.slot, driven_request.value,
                                driven_request.key};
                    s_tuser <= driven_request.action;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: checks each result against the oldest prediction, and stalls
    // at random or for one long hold when asked to.
    always @(posedge aclk) begin
        map_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result with no request outstanding: tuser %0d tdata %h",
                           m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[9:0] !== want.slot_index) begin
                        $error("slot_index: expected %0d, got %0d", want.slot_index,
                               m_tdata[9:0]);
                        error_count++;
                    end
                    if (m_tdata[41:10] !== want.entry_key) begin
                        $error("entry_key: expected %h, got %h", want.entry_key,
                               m_tdata[41:10]);
                        error_count++;
                    end
                    if (m_tdata[73:42] !== want.entry_value) begin
                        $error("entry_value: expected %h, got %h", want.entry_value,
                               m_tdata[73:42]);
                        error_count++;
                    end
                    if (m_tdata[84:74] !== want.loaded_cells) begin
                        $error("loaded_cells: expected %0d, got %0d", want.loaded_cells,
                               m_tdata[84:74]);
                        error_count++;
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_count = HOLD_CYCLES;
            end
            if (hold_count != 0) begin
                hold_count--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_linear_probe_hash_map_unit NOT OK");
            $finish;
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [9:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_SIZE_LOG2: begin
                model_size_log2 = data[3:0];
                foreach (model_state[i]) model_state[i] = ST_EMPTY;
                model_loaded = 0;
                model_dead = 0;
            end
            CFG_LOAD_LIMIT: model_load_limit = data;
            default: model_hash_select = data[1:0];
        endcase
    endtask

    // Every result back: the unit is idle, so registers may be written.
    task automatic wait_until_drained();
        while (request_queue.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic queue_request(input logic [1:0] action, input logic [31:0] key,
                                 input logic [31:0] value, input logic [9:0] slot);
        map_request_t rq;
        rq.action = action;
        rq.key = key;
        rq.value = value;
        rq.slot = slot;
        request_queue.push_back(rq);
    endtask

    // Random requests drawn mostly from a small key set, so that puts,
    // finds and deletes keep meeting each other in the table.
    task automatic queue_random(input int count);
        int unsigned pick, n;
        logic [31:0] key;
        logic [9:0] slot;
        n = table_slots();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            key = ($urandom_range(9) < 7) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                          : $urandom;
            slot = ($urandom_range(4) != 0) ? 10'($urandom_range(n - 1))
                                            : 10'($urandom_range(1023));
            if (pick < 42) queue_request(ACT_PUT, key, $urandom, slot);
            else if (pick < 66) queue_request(ACT_FIND, key, $urandom, slot);
            else if (pick < 84) queue_request(ACT_DEL_KEY, key, $urandom, slot);
            else queue_request(ACT_DEL_SLOT, key, $urandom, slot);
        end
    endtask

    // One setting of the table with one idling mode. A new size empties the
    // table, so a fresh key set is drawn; without one the old keys remain.
    task automatic run_phase(input int size_log2, input int load_limit, input int hash_sel,
                             input bit new_size, input int idle_mode, input int count,
                             input int pool_size);
        wait_until_drained();
        if (new_size) begin
            write_register(CFG_SIZE_LOG2, 10'(size_log2));
            key_pool.delete();
            for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
        end
        write_register(CFG_LOAD_LIMIT, 10'(load_limit));
        write_register(CFG_HASH_SELECT, 10'(hash_sel));
        case (idle_mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
        queue_random(count);
    endtask

    initial begin
        model_size_log2 = 4'd8;
        model_load_limit = 10'd192;
        model_hash_select = HASH_SIX_STEP;
        model_loaded = 0;
        model_dead = 0;
        foreach (model_state[i]) model_state[i] = ST_EMPTY;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at the reset settings: the key and value extremes,
        // an overwrite, misses, both kinds of delete and a slot past the end.
        queue_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000, 10'd0);
        queue_request(ACT_PUT, 32'h7fff_ffff, 32'h8000_0000, 10'd0);
        queue_request(ACT_PUT, 32'h8000_0000, 32'hffff_ffff, 10'd0);
        queue_request(ACT_PUT, 32'hffff_ffff, 32'h7fff_ffff, 10'd0);
        queue_request(ACT_PUT, 32'h0000_0000, 32'h5a5a_a5a5, 10'd0);
        queue_request(ACT_FIND, 32'h0000_0000, 32'h0, 10'd0);
        queue_request(ACT_FIND, 32'h0000_3039, 32'h0, 10'd0);
        queue_request(ACT_FIND, 32'hffff_ffff, 32'h0, 10'd0);
        queue_request(ACT_DEL_KEY, 32'h8000_0000, 32'h0, 10'd0);
        queue_request(ACT_DEL_KEY, 32'h8000_0000, 32'h0, 10'd0);
        queue_request(ACT_FIND, 32'h8000_0000, 32'h0, 10'd0);
        queue_request(ACT_DEL_SLOT, 32'h0, 32'h0, 10'd1023);
        queue_request(ACT_DEL_SLOT, 32'hffff_ffff, 32'hffff_ffff, 10'd255);
        queue_request(ACT_DEL_SLOT, 32'h0, 32'h0, 10'd0);
        queue_request(ACT_DEL_KEY, 32'h7fff_ffff, 32'h0, 10'd0);
        queue_request(ACT_DEL_KEY, 32'hffff_ffff, 32'h0, 10'd0);
        queue_request(ACT_DEL_KEY, 32'h0000_0000, 32'h0, 10'd0);
        queue_request(ACT_FIND, 32'h0000_0000, 32'h0, 10'd0);
        for (int i = 0; i < 40; i++) key_pool.push_back($urandom);
        queue_random(100);

        // The receiver holds off for a long stretch while requests keep
        // coming, so that the unit's queue fills and s_tready drops.
        hold_request = 1'b1;

        run_phase(2, 3, HASH_MULTIPLY, 1'b1, 1, 120, 6);
        run_phase(10, 1023, HASH_FIVE_SHIFT, 1'b1, 2, 150, 200);
        // Size below range clamps to four slots; a zero limit fills nothing.
        run_phase(0, 0, HASH_SHIFT_ONLY, 1'b1, 3, 60, 8);
        // Size above range clamps to the full store.
        run_phase(15, 700, HASH_SHIFT_ONLY, 1'b1, 0, 150, 300);
        // A limit beyond the slot count is clamped, so the table runs full.
        run_phase(3, 1023, HASH_SIX_STEP, 1'b1, 1, 150, 12);
        // New hash over old contents: stored keys may now be missed.
        run_phase(3, 1023, HASH_MULTIPLY, 1'b0, 2, 100, 12);
        run_phase(4, 15, HASH_FIVE_SHIFT, 1'b1, 3, 150, 24);
        run_phase(6, 40, HASH_MULTIPLY, 1'b1, 0, 150, 80);
        run_phase(5, 1, HASH_SIX_STEP, 1'b1, 2, 100, 10);
        run_phase(8, 192, HASH_SHIFT_ONLY, 1'b1, 1, 150, 200);

        wait_until_drained();
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("tb_linear_probe_hash_map_unit OK");
        else
            $display("tb_linear_probe_hash_map_unit NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/lphm_pkg.sv
rtl/lphm_front.sv
rtl/lphm_fifo.sv
rtl/lphm_back.sv
rtl/linear_probe_hash_map_unit.sv
tb/tb_linear_probe_hash_map_unit.sv
